>>> sv/bfc_pkg.sv
// Shared types, constants and the CRC-8 update function for the block framer.
package bfc_pkg;

	localparam int BLOCK_BYTES = 8;
	localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
	localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h07;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_CRC     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_HEADER,
		ST_PAYLOAD,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic wr;
		logic ld_header;
		logic ld_payload;
		logic ld_check;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic frame_due;
		logic pay_last;
	} status_t;

	// One byte through CRC-8, polynomial 0x07, most significant bit first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> sv/bfc_ctrl.sv
// Controller state machine: collects bytes, then steps through header, payload and check.
module bfc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bfc_pkg::status_t status,
	output bfc_pkg::cmd_t    cmd
);

	bfc_pkg::state_t state_q;
	bfc_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfc_pkg::ST_COLLECT;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bfc_pkg::ST_COLLECT: begin
				if (s_tvalid && status.frame_due) state_next = bfc_pkg::ST_HEADER;
			end
			bfc_pkg::ST_HEADER: begin
				if (status.slot_free) state_next = bfc_pkg::ST_PAYLOAD;
			end
			bfc_pkg::ST_PAYLOAD: begin
				if (status.slot_free && status.pay_last) state_next = bfc_pkg::ST_CHECK;
			end
			bfc_pkg::ST_CHECK: begin
				if (status.slot_free) state_next = bfc_pkg::ST_COLLECT;
			end
			default: state_next = bfc_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			bfc_pkg::ST_COLLECT: begin
				s_tready = 1'b1;
				cmd.wr   = s_tvalid;
			end
			bfc_pkg::ST_HEADER:  cmd.ld_header  = status.slot_free;
			bfc_pkg::ST_PAYLOAD: cmd.ld_payload = status.slot_free;
			bfc_pkg::ST_CHECK:   cmd.ld_check   = status.slot_free;
			default: ;
		endcase
	end

endmodule

>>> sv/bfc_dp.sv
// Datapath: block buffer, fill count, running CRC, read pointer and output register.
module bfc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       s_tdata,
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast,
	input  bfc_pkg::cmd_t    cmd,
	output bfc_pkg::status_t status
);

	logic [7:0]    store_q [bfc_pkg::BLOCK_BYTES];
	bfc_pkg::cnt_t count_q;
	bfc_pkg::cnt_t rd_q;
	logic [7:0]    crc_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic [1:0]    out_kind_q;
	logic          out_last_q;
	bfc_pkg::cnt_t rd_next;

	assign rd_next = rd_q + bfc_pkg::cnt_t'(1);

	assign status.slot_free = !out_valid_q || m_tready;
	assign status.frame_due = (count_q == bfc_pkg::cnt_t'(bfc_pkg::BLOCK_BYTES - 1)) || s_tlast;
	assign status.pay_last  = (rd_next == count_q);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			store_q[count_q[bfc_pkg::IDX_W-1:0]] <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= bfc_pkg::CRC_INIT;
			rd_q    <= '0;
		end else begin
			if (cmd.wr) begin
				count_q <= count_q + bfc_pkg::cnt_t'(1);
				crc_q   <= bfc_pkg::crc8_update(crc_q, s_tdata);
			end else if (cmd.ld_check) begin
				count_q <= '0;
				crc_q   <= bfc_pkg::CRC_INIT;
			end
			if (cmd.ld_header) begin
				rd_q <= '0;
			end else if (cmd.ld_payload) begin
				rd_q <= rd_next;
			end
		end
	end

	// The output register holds a beat until it is taken; a new beat may replace it on the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_header || cmd.ld_payload || cmd.ld_check) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_header) begin
			out_byte_q <= 8'(count_q);
			out_kind_q <= bfc_pkg::KIND_HEADER;
			out_last_q <= 1'b0;
		end else if (cmd.ld_payload) begin
			out_byte_q <= store_q[rd_q[bfc_pkg::IDX_W-1:0]];
			out_kind_q <= bfc_pkg::KIND_PAYLOAD;
			out_last_q <= 1'b0;
		end else if (cmd.ld_check) begin
			out_byte_q <= crc_q;
			out_kind_q <= bfc_pkg::KIND_CRC;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

>>> sv/block_framer_crc8.sv
// Top level of the block framer: length header, buffered payload and CRC-8 per block.
//
//   channel  beat carries                      tdata            tuser       tlast
//   s_*      one payload byte                  data_byte[7:0]   -           final_byte
//   m_*      header, payload or check byte     out_byte[7:0]    out_kind    run_last
//
// A byte that does not close a block is stored with input still ready. A byte that fills the
// block or carries tlast is followed by fill count + 2 output beats, one per cycle unless
// m_tready stalls, from the single output register, during which no input is taken.
// Reset clears the fill count, read pointer, CRC (to 0xFF) and output valid; the buffer is not
// cleared. A stall on m_tready holds the current beat and pauses the frame sequence.
module block_framer_crc8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] out_kind
	output logic       m_tlast
);

	bfc_pkg::cmd_t    cmd;
	bfc_pkg::status_t status;

	bfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bfc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.status   (status)
	);

endmodule
